[src/pdaf_pkg.sv]
package pdaf_pkg;

  localparam int unsigned ConfW    = 11;
  localparam int unsigned GainW    = 8;
  localparam int unsigned LimitW   = 10;
  localparam int unsigned FramesW  = 5;
  localparam int unsigned PhaseW   = 11;
  localparam int unsigned SumW     = 20;
  localparam int unsigned CntW     = 9;
  localparam int unsigned AccW     = 16;
  localparam int unsigned LensW    = 10;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  localparam int unsigned DivW    = 20;
  localparam int unsigned DivStpW = 5;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;

  localparam logic [CntW-1:0]    CntMax        = 9'd511;
  localparam logic [FramesW-1:0] MaxAvgFrames  = 5'd16;
  localparam logic [LensW-1:0]   LensMax       = 10'd1023;
  localparam logic [LensW-1:0]   LensReset     = 10'd512;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_THRESHOLD = 3'd0,
    CFG_GAIN      = 3'd1,
    CFG_LIMIT     = 3'd2,
    CFG_FRAMES    = 3'd3,
    CFG_ENABLE    = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [ConfW-1:0]   threshold;
    logic [GainW-1:0]   gain;
    logic [LimitW-1:0]  limit;
    logic [FramesW-1:0] frames;
    logic               enable;
  } cfg_t;

  typedef struct packed {
    logic signed [SumW-1:0] sum;
    logic [CntW-1:0]        cnt;
  } frame_t;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [CntW-1:0] divisor;
  } div_req_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_MEAN,
    ST_ACCUM,
    ST_MUL,
    ST_SCALE,
    ST_CLAMP,
    ST_SUM,
    ST_DIV_POS,
    ST_OUT
  } back_state_e;

endpackage

[src/pdaf_rec_if.sv]
interface pdaf_rec_if;
  logic       valid;
  logic       ready;
  logic [7:0] record_byte_first;
  logic [7:0] record_byte_second;
  logic [7:0] record_byte_third;
  logic       last_window;

  modport source (
    output valid, record_byte_first, record_byte_second, record_byte_third, last_window,
    input  ready
  );
  modport sink (
    input  valid, record_byte_first, record_byte_second, record_byte_third, last_window,
    output ready
  );
endinterface

[src/pdaf_res_if.sv]
interface pdaf_res_if;
  logic               valid;
  logic               ready;
  logic [9:0]         lens_position;
  logic               frame_valid;
  logic signed [10:0] frame_mean;
  logic               lens_moved;

  modport source (
    output valid, lens_position, frame_valid, frame_mean, lens_moved,
    input  ready
  );
  modport sink (
    input  valid, lens_position, frame_valid, frame_mean, lens_moved,
    output ready
  );
endinterface

[src/pdaf_front.sv]
module pdaf_front
  import pdaf_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  pdaf_rec_if.sink         rec_i,
  input  logic [ConfW-1:0] threshold_i,
  input  logic             full_i,
  output logic             push_o,
  output frame_t           push_data_o
);

  logic signed [SumW-1:0] sum_q, sum_d;
  logic [CntW-1:0]        cnt_q, cnt_d;
  logic [ConfW-1:0]       conf;
  logic signed [PhaseW-1:0] phase;
  logic                   qualify;
  logic                   accept;

  assign rec_i.ready = !full_i;
  assign accept      = rec_i.valid && rec_i.ready;

  assign conf  = {rec_i.record_byte_first, rec_i.record_byte_second[7:5]};
  assign phase = $signed({rec_i.record_byte_second[4:0], rec_i.record_byte_third[7:2]});

  // The count saturates so that the sum can never overflow.
  assign qualify = (conf >= threshold_i) && (cnt_q != CntMax);

  always_comb begin
    sum_d = sum_q;
    cnt_d = cnt_q;
    if (qualify) begin
      sum_d = sum_q + {{(SumW-PhaseW){phase[PhaseW-1]}}, phase};
      cnt_d = cnt_q + 1'b1;
    end
  end

  assign push_o      = accept && rec_i.last_window;
  assign push_data_o = '{sum: sum_d, cnt: cnt_d};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (rec_i.last_window) begin
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

[src/pdaf_fifo.sv]
module pdaf_fifo
  import pdaf_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  frame_t data_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   valid_o,
  output frame_t data_o
);

  frame_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QueuePtrW:0]    level_q;

  assign full_o  = (level_q == (QueuePtrW+1)'(QueueDepth));
  assign valid_o = (level_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        level_q <= level_q + 1'b1;
      end else if (pop_i && !push_i) begin
        level_q <= level_q - 1'b1;
      end
    end
  end

endmodule

[src/pdaf_div.sv]
module pdaf_div
  import pdaf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  div_req_t        req_i,
  output logic            done_o,
  output logic [DivW-1:0] quotient_o
);

  logic [DivW-1:0]    q_q;
  logic [CntW-1:0]    rem_q;
  logic [CntW-1:0]    divisor_q;
  logic [DivStpW-1:0] step_q;
  logic               busy_q;
  logic               done_q;
  logic [CntW:0]      trial;
  logic               ge;

  // One quotient bit per cycle, restoring form.
  assign trial = {rem_q, q_q[DivW-1]};
  assign ge    = (trial >= {1'b0, divisor_q});

  assign done_o     = done_q;
  assign quotient_o = q_q;

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      q_q       <= req_i.dividend;
      rem_q     <= '0;
      divisor_q <= req_i.divisor;
    end else if (busy_q) begin
      q_q   <= {q_q[DivW-2:0], ge};
      rem_q <= ge ? CntW'(trial - {1'b0, divisor_q}) : trial[CntW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        step_q <= DivStpW'(DivW);
      end else if (busy_q) begin
        step_q <= step_q - 1'b1;
        if (step_q == DivStpW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[src/pdaf_back.sv]
module pdaf_back
  import pdaf_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  cfg_t            cfg_i,
  input  logic            fifo_valid_i,
  input  frame_t          fifo_data_i,
  output logic            pop_o,
  output div_req_t        div_req_o,
  input  logic            div_done_i,
  input  logic [DivW-1:0] div_quot_i,
  pdaf_res_if.source      res_o
);

  back_state_e state_q, state_d;

  logic                     sign_q;
  logic signed [PhaseW-1:0] mean_q;
  logic signed [AccW-1:0]   acc_q;
  logic [FramesW-1:0]       fa_q;
  logic [LensW-1:0]         lens_q;
  logic                     valid_q;
  logic                     moved_q;
  logic signed [23:0]       num_q;
  logic [22:0]              lim_q;
  logic [22:0]              tden_q;

  logic                     res_valid_q;
  logic [LensW-1:0]         res_lens_q;
  logic                     res_fvalid_q;
  logic signed [PhaseW-1:0] res_mean_q;
  logic                     res_moved_q;

  logic [SumW-1:0]          sum_mag;
  logic signed [AccW:0]     acc_sum;
  logic signed [AccW-1:0]   acc_sat;
  logic [FramesW-1:0]       fa_inc;
  logic [FramesW-1:0]       n_eff;
  logic                     update_due;
  logic signed [24:0]       prod;
  logic [14:0]              lim_prod;
  logic [14:0]              tden_prod;
  logic signed [23:0]       lim_s;
  logic signed [23:0]       total;
  logic                     out_free;

  assign sum_mag = fifo_data_i.sum[SumW-1] ? SumW'(-fifo_data_i.sum)
                                            : SumW'(fifo_data_i.sum);

  assign acc_sum = {acc_q[AccW-1], acc_q} + {{(AccW+1-PhaseW){mean_q[PhaseW-1]}}, mean_q};

  always_comb begin
    if (acc_sum > 17'sd32767) begin
      acc_sat = 16'sh7FFF;
    end else if (acc_sum < -17'sd32768) begin
      acc_sat = 16'sh8000;
    end else begin
      acc_sat = acc_sum[AccW-1:0];
    end
  end

  assign fa_inc = fa_q + 1'b1;

  always_comb begin
    if (cfg_i.frames == '0) begin
      n_eff = FramesW'(1);
    end else if (cfg_i.frames > MaxAvgFrames) begin
      n_eff = MaxAvgFrames;
    end else begin
      n_eff = cfg_i.frames;
    end
  end

  assign update_due = (fa_inc >= n_eff);

  assign prod      = acc_q * $signed({1'b0, cfg_i.gain});
  assign lim_prod  = {5'b0, cfg_i.limit} * {10'b0, fa_q};
  assign tden_prod = {5'b0, lens_q} * {10'b0, fa_q};
  assign lim_s     = $signed({1'b0, lim_q});
  assign total     = $signed({1'b0, tden_q}) + num_q;

  assign out_free = !res_valid_q || res_o.ready;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (fifo_valid_i) begin
          state_d = (fifo_data_i.cnt == '0) ? ST_ACCUM : ST_DIV_MEAN;
        end
      end
      ST_DIV_MEAN: begin
        if (div_done_i) begin
          state_d = ST_ACCUM;
        end
      end
      ST_ACCUM: begin
        if (mean_q != '0 && update_due && cfg_i.enable) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_OUT;
        end
      end
      ST_MUL:   state_d = ST_SCALE;
      ST_SCALE: state_d = ST_CLAMP;
      ST_CLAMP: state_d = ST_SUM;
      ST_SUM:   state_d = total[23] ? ST_OUT : ST_DIV_POS;
      ST_DIV_POS: begin
        if (div_done_i) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    pop_o     = 1'b0;
    div_req_o = '{start: 1'b0, dividend: '0, divisor: '0};
    case (state_q)
      ST_IDLE: begin
        pop_o = fifo_valid_i;
        if (fifo_valid_i && fifo_data_i.cnt != '0) begin
          div_req_o = '{start: 1'b1, dividend: sum_mag, divisor: fifo_data_i.cnt};
        end
      end
      ST_SUM: begin
        if (!total[23]) begin
          div_req_o = '{start:    1'b1,
                        dividend: {4'b0, total[23:8]},
                        divisor:  {4'b0, fa_q}};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        sign_q <= fifo_data_i.sum[SumW-1];
        mean_q <= '0;
      end
      ST_DIV_MEAN: begin
        if (div_done_i) begin
          mean_q <= sign_q ? PhaseW'(-div_quot_i[PhaseW-1:0]) : div_quot_i[PhaseW-1:0];
        end
      end
      ST_ACCUM: begin
        valid_q <= (mean_q != '0);
        moved_q <= 1'b0;
      end
      ST_MUL:   num_q <= prod[23:0];
      ST_SCALE: begin
        lim_q  <= {lim_prod, 8'b0};
        tden_q <= {tden_prod, 8'b0};
      end
      ST_CLAMP: begin
        if (num_q > lim_s) begin
          num_q <= lim_s;
        end else if (num_q < -lim_s) begin
          num_q <= -lim_s;
        end
      end
      ST_SUM:   moved_q <= 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      acc_q   <= '0;
      fa_q    <= '0;
      lens_q  <= LensReset;
    end else begin
      state_q <= state_d;
      case (state_q)
        ST_ACCUM: begin
          if (mean_q != '0) begin
            if (update_due && !cfg_i.enable) begin
              acc_q <= '0;
              fa_q  <= '0;
            end else begin
              acc_q <= acc_sat;
              fa_q  <= fa_inc;
            end
          end
        end
        ST_SUM: begin
          if (total[23]) begin
            lens_q <= '0;
            acc_q  <= '0;
            fa_q   <= '0;
          end
        end
        ST_DIV_POS: begin
          if (div_done_i) begin
            lens_q <= (div_quot_i > DivW'(LensMax)) ? LensMax : div_quot_i[LensW-1:0];
            acc_q  <= '0;
            fa_q   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (state_q == ST_OUT && out_free) begin
      res_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_OUT && out_free) begin
      res_lens_q   <= lens_q;
      res_fvalid_q <= valid_q;
      res_mean_q   <= mean_q;
      res_moved_q  <= moved_q;
    end
  end

  assign res_o.valid         = res_valid_q;
  assign res_o.lens_position = res_lens_q;
  assign res_o.frame_valid   = res_fvalid_q;
  assign res_o.frame_mean    = res_mean_q;
  assign res_o.lens_moved    = res_moved_q;

endmodule

[src/phase_detect_autofocus_loop_core.sv]
// Phase-detection autofocus loop. The record channel takes one three-byte PDAF
// window record per transaction and sustains one transaction per clock while a
// frame streams in; records produce no output except the one marked as the last
// window of its frame, which yields exactly one result transaction carrying the
// lens target, the frame mean and two status flags. Frame-end work runs in a
// separate back end behind a two-entry frame queue: the frame mean takes a
// 20-step bit-serial division that holds the back end (skipped when no window
// qualified), and a focus update adds multiply, scale, clamp and sum steps plus
// a second such division unless the new position is negative; the result may
// then wait for the consumer. The record channel stalls only when two completed
// frames are already waiting for the back end, which happens only when frames
// are shorter than the back end's time per frame. Configuration registers are
// written through the plain write port while the block is idle, a rule for the
// user; the block itself does not enforce it.

module phase_detect_autofocus_loop_core
  import pdaf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pdaf_rec_if.sink            rec_i,
  pdaf_res_if.source          res_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // Configuration registers, reset to their documented defaults.
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{threshold: 11'd10, gain: 8'd32, limit: 10'd100,
                 frames: 5'd1, enable: 1'b0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_THRESHOLD: cfg_q.threshold <= cfg_data_i[ConfW-1:0];
        CFG_GAIN:      cfg_q.gain      <= cfg_data_i[GainW-1:0];
        CFG_LIMIT:     cfg_q.limit     <= cfg_data_i[LimitW-1:0];
        CFG_FRAMES:    cfg_q.frames    <= cfg_data_i[FramesW-1:0];
        CFG_ENABLE:    cfg_q.enable    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // The front end unpacks each record, qualifies it against the confidence
  // threshold and keeps the running frame sum and count. At the last window it
  // pushes the frame totals into the queue and starts the next frame from zero.
  logic   push;
  frame_t push_data;
  logic   full;

  pdaf_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_i       (rec_i),
    .threshold_i (cfg_q.threshold),
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // The frame queue decouples record intake from frame-end processing.
  logic   pop;
  logic   fifo_valid;
  frame_t fifo_data;

  pdaf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_data),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (fifo_valid),
    .data_o  (fifo_data)
  );

  // One shared iterative divider serves both the frame mean (truncated toward
  // zero, sign handled around the unsigned core) and the new lens position.
  div_req_t        div_req;
  logic            div_done;
  logic [DivW-1:0] div_quot;

  pdaf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (div_req),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // The back end accumulates nonzero frame means, decides when a focus update
  // is due and computes the clamped lens step in exact fixed point, then places
  // the result in an output register so it can wait for the consumer.
  pdaf_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .fifo_valid_i (fifo_valid),
    .fifo_data_i  (fifo_data),
    .pop_o        (pop),
    .div_req_o    (div_req),
    .div_done_i   (div_done),
    .div_quot_i   (div_quot),
    .res_o        (res_o)
  );

endmodule

[sim/pdaf_focus_checker.sv]
`timescale 1ns / 100ps

module pdaf_focus_checker
  import pdaf_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pdaf_rec_if                 rec_i,
  pdaf_res_if                 res_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);

  typedef struct packed {
    logic [LensW-1:0]         lens;
    logic                     valid;
    logic signed [PhaseW-1:0] mean;
    logic                     moved;
  } focus_result_t;

  focus_result_t expected_focus_results[$];

  // Shadow copy of the registers and of the loop state.
  cfg_t             cfg;
  int               frame_sum;
  int unsigned      frame_cnt;
  int               mean_acc;
  int unsigned      frames_acc;
  logic [LensW-1:0] lens;

  task automatic advance_focus_loop(input logic [7:0] b0, input logic [7:0] b1,
                                    input logic [7:0] b2, input logic last);
    logic [ConfW-1:0]         conf;
    logic signed [PhaseW-1:0] phase;
    int                       mean;
    int unsigned              n;
    longint                   den;
    longint                   num;
    longint                   lim;
    longint                   total;
    longint                   pos;
    focus_result_t            r;
    conf  = {b0, b1[7:5]};
    phase = {b1[4:0], b2[7:2]};
    if (conf >= cfg.threshold && frame_cnt < CntMax) begin
      frame_sum += int'(phase);
      frame_cnt++;
    end
    if (!last) return;

    mean    = 0;
    r.valid = 1'b0;
    r.moved = 1'b0;
    if (frame_cnt != 0) mean = frame_sum / int'(frame_cnt);
    frame_sum = 0;
    frame_cnt = 0;

    if (mean != 0) begin
      mean_acc += mean;
      if (mean_acc > 32767) mean_acc = 32767;
      if (mean_acc < -32768) mean_acc = -32768;
      r.valid = 1'b1;
      frames_acc++;
      n = cfg.frames;
      if (n == 0) n = 1;
      if (n > MaxAvgFrames) n = MaxAvgFrames;
      if (frames_acc >= n) begin
        if (cfg.enable) begin
          // Work in units of 1/(256*frames) so the step is exact until the
          // final truncation of the new position.
          den = 256 * longint'(frames_acc);
          num = longint'(mean_acc) * longint'(cfg.gain);
          lim = longint'(cfg.limit) * den;
          if (num > lim) num = lim;
          if (num < -lim) num = -lim;
          total = longint'(lens) * den + num;
          if (total < 0) begin
            lens = '0;
          end else begin
            pos  = total / den;
            lens = (pos > 1023) ? LensMax : pos[LensW-1:0];
          end
          r.moved = 1'b1;
        end
        mean_acc   = 0;
        frames_acc = 0;
      end
    end
    r.lens = lens;
    r.mean = mean[PhaseW-1:0];
    expected_focus_results.push_back(r);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      fail_count_o++;
    end
  endfunction

  task automatic check_focus_result();
    focus_result_t want;
    if (expected_focus_results.size() == 0) begin
      $error("unexpected result: lens_position %0d frame_valid %0d frame_mean %0d",
             res_i.lens_position, res_i.frame_valid, res_i.frame_mean);
      fail_count_o++;
      return;
    end
    want = expected_focus_results.pop_front();
    check_field("lens_position", int'(want.lens), int'(res_i.lens_position));
    check_field("frame_valid", int'(want.valid), int'(res_i.frame_valid));
    check_field("frame_mean", int'(want.mean), int'(res_i.frame_mean));
    check_field("lens_moved", int'(want.moved), int'(res_i.lens_moved));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg.threshold = 11'd10;
      cfg.gain      = 8'd32;
      cfg.limit     = 10'd100;
      cfg.frames    = 5'd1;
      cfg.enable    = 1'b0;
      frame_sum     = 0;
      frame_cnt     = 0;
      mean_acc      = 0;
      frames_acc    = 0;
      lens          = LensReset;
      expected_focus_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_THRESHOLD: cfg.threshold = cfg_data_i[ConfW-1:0];
          CFG_GAIN:      cfg.gain      = cfg_data_i[GainW-1:0];
          CFG_LIMIT:     cfg.limit     = cfg_data_i[LimitW-1:0];
          CFG_FRAMES:    cfg.frames    = cfg_data_i[FramesW-1:0];
          CFG_ENABLE:    cfg.enable    = cfg_data_i[0];
          default: ;
        endcase
      end
      if (rec_i.valid && rec_i.ready) begin
        advance_focus_loop(rec_i.record_byte_first, rec_i.record_byte_second,
                           rec_i.record_byte_third, rec_i.last_window);
      end
      if (res_i.valid && res_i.ready) check_focus_result();
    end
    pending_o = expected_focus_results.size();
  end

endmodule

[sim/tb_phase_detect_autofocus_loop_core.sv]
`timescale 1ns / 100ps

module tb_phase_detect_autofocus_loop_core;
  import pdaf_pkg::*;

  // Idling patterns for the record sender and the result receiver.
  typedef enum int {
    IDLE_NONE,
    IDLE_SRC,
    IDLE_SNK,
    IDLE_BOTH
  } idle_mode_e;

  // Enough quiet cycles after the last result for the back end to finish a
  // frame end with a focus update, which leaves the block idle.
  localparam int DrainCycles = 80;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_data;
  int unsigned         fail_count;
  int unsigned         pending;

  // Stimulus shaping: the threshold currently programmed and the idle rates.
  int                  cur_thr;
  int                  src_idle_pct;
  int                  snk_stall_pct;

  pdaf_rec_if rec_ch ();
  pdaf_res_if res_ch ();

  phase_detect_autofocus_loop_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rec_i      (rec_ch),
    .res_o      (res_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  pdaf_focus_checker checker_i (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rec_i        (rec_ch),
    .res_i        (res_ch),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_data_i   (cfg_data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // The receiver draws a fresh stall decision every cycle. Ready stays low
  // while reset is asserted.
  always @(posedge clk_i) begin
    res_ch.ready <= rst_ni && ($urandom_range(99) >= snk_stall_pct);
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  task automatic set_idling(input idle_mode_e mode);
    src_idle_pct  = (mode == IDLE_SRC) ? 50 : (mode == IDLE_BOTH) ? 37 : 0;
    snk_stall_pct = (mode == IDLE_SNK) ? 50 : (mode == IDLE_BOTH) ? 37 : 0;
  endtask

  // One register write per clock. The write enable is left high so that
  // back-to-back writes never lower and raise it in the same time step.
  task automatic put_reg(input cfg_idx_e idx, input int value);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value[CfgDataW-1:0];
    @(posedge clk_i);
  endtask

  task automatic write_settings(input int thr, input int gain, input int limit,
                                input int frames, input int en);
    put_reg(CFG_THRESHOLD, thr);
    put_reg(CFG_GAIN, gain);
    put_reg(CFG_LIMIT, limit);
    put_reg(CFG_FRAMES, frames);
    put_reg(CFG_ENABLE, en);
    cfg_we  <= 1'b0;
    cur_thr  = thr;
  endtask

  // Drives one window record and returns right after the edge at which the
  // transaction completed. Valid is left high; the next call or the caller
  // lowers it. Random gaps are inserted in front of the record.
  task automatic send_window(input int conf, input int phase, input bit last);
    logic [ConfW-1:0]  c;
    logic [PhaseW-1:0] p;
    c = conf[ConfW-1:0];
    p = phase[PhaseW-1:0];
    while ($urandom_range(99) < src_idle_pct) begin
      rec_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    rec_ch.valid              <= 1'b1;
    rec_ch.record_byte_first  <= c[10:3];
    rec_ch.record_byte_second <= {c[2:0], p[10:6]};
    // The two low bits of the third byte are unused; keep them toggling.
    rec_ch.record_byte_third  <= {p[5:0], 2'($urandom_range(3))};
    rec_ch.last_window        <= last;
    @(posedge clk_i);
    while (!rec_ch.ready) @(posedge clk_i);
  endtask

  // Mostly qualifying windows so that frames carry a mean, with small phases
  // that often cancel out into a zero mean, the phase extremes and otherwise any phase.
  task automatic send_random_window(input bit last);
    int conf;
    int phase;
    int pick;
    if ($urandom_range(99) < 15) conf = int'($urandom_range(2047));
    else conf = int'($urandom_range(2047, cur_thr));
    pick = int'($urandom_range(99));
    if (pick < 40) phase = int'($urandom_range(8)) - 4;
    else if (pick < 50) phase = $urandom_range(1) ? 1023 : -1024;
    else phase = int'($urandom_range(2047));
    send_window(conf, phase, last);
  endtask

  // Frames are mostly short so that frame ends, and thus results, are
  // frequent, with a few longer ones in between.
  task automatic send_random_frame(output int len);
    int pick;
    pick = int'($urandom_range(99));
    if (pick < 60) len = int'($urandom_range(4, 1));
    else if (pick < 90) len = int'($urandom_range(20, 5));
    else len = int'($urandom_range(60, 21));
    for (int i = 0; i < len; i++) send_random_window(i == len - 1);
  endtask

  // Stops the sender, waits for every outstanding result, then lets the back
  // end settle so that the block is left idle.
  task automatic wait_idle();
    rec_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic run_phase(input int thr, input int gain, input int limit, input int frames,
                           input int en, input idle_mode_e mode, input int n_records);
    int sent;
    int len;
    bit paused;
    sent   = 0;
    paused = 1'b0;
    wait_idle();
    write_settings(thr, gain, limit, frames, en);
    set_idling(mode);
    while (sent < n_records) begin
      send_random_frame(len);
      sent += len;
      // Once per phase with both sides idling, the sender holds off until the queue
      // of expected results has emptied, then resumes.
      if (mode == IDLE_BOTH && !paused && sent >= n_records / 2) begin
        wait_idle();
        paused = 1'b1;
      end
    end
  endtask

  initial begin
    rst_ni                    = 1'b0;
    cfg_we                    = 1'b0;
    cfg_idx                   = '0;
    cfg_data                  = '0;
    rec_ch.valid              = 1'b0;
    rec_ch.record_byte_first  = '0;
    rec_ch.record_byte_second = '0;
    rec_ch.record_byte_third  = '0;
    rec_ch.last_window        = 1'b0;
    cur_thr                   = 10;
    set_idling(IDLE_NONE);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part with reset-like settings and autofocus on.
    write_settings(10, 32, 100, 1, 1);
    // A frame whose only window falls below the threshold is empty.
    send_window(0, 300, 1'b1);
    // Extreme phases cancel to a zero mean and the frame is dropped.
    send_window(2047, 1023, 1'b0);
    send_window(2047, -1024, 1'b1);
    // Largest positive and negative mean: the step hits the move limit.
    send_window(2047, 1023, 1'b1);
    send_window(1023, -1024, 1'b1);
    // One window just below and one exactly at the threshold.
    send_window(9, 500, 1'b0);
    send_window(10, 7, 1'b1);
    // A fractional negative step truncates the position downward.
    send_window(1024, -3, 1'b1);
    // The mean of -3 and -4 truncates toward zero.
    send_window(500, -3, 1'b0);
    send_window(600, -4, 1'b1);

    // Measuring only, with a frame count of zero that behaves as one.
    wait_idle();
    write_settings(10, 255, 1023, 0, 0);
    send_window(2047, 1023, 1'b1);
    send_window(256, -1, 1'b1);

    // Full gain and limit drive the lens into both ends of its range.
    wait_idle();
    write_settings(0, 255, 1023, 1, 1);
    send_window(0, 1023, 1'b1);
    send_window(0, 1023, 1'b1);
    send_window(0, -1024, 1'b1);
    send_window(0, -1024, 1'b1);

    // Random part, cycling through the idling patterns.
    run_phase(10, 32, 100, 1, 1, IDLE_NONE, 220);
    run_phase(0, 255, 1023, 1, 1, IDLE_SRC, 220);
    run_phase(2047, 0, 0, 16, 1, IDLE_SNK, 200);
    run_phase(100, 200, 50, 3, 1, IDLE_BOTH, 220);
    // A count above the maximum acts as the maximum; measuring only leaves
    // partly accumulated frames behind for the next phase.
    run_phase(5, 17, 1023, 31, 0, IDLE_NONE, 150);
    // The count is lowered below what has already been accumulated.
    run_phase(0, 128, 300, 2, 1, IDLE_SRC, 200);
    run_phase(700, 16, 10, 5, 1, IDLE_BOTH, 220);

    // One frame with more qualifying windows than the counter holds; the
    // windows past the full count must be ignored.
    wait_idle();
    write_settings(0, 64, 1023, 1, 1);
    set_idling(IDLE_BOTH);
    for (int i = 0; i < 520; i++) send_random_window(i == 519);

    wait_idle();
    if (fail_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
